// File: rtl/core/gha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generation-tagged handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int COUNT_W   = SLOT_W + 1;
    localparam int GEN_SHIFT = 12;
    localparam int HANDLE_W  = 31;
    localparam int FSLOT_W   = 10;

    localparam logic [31:0] GEN_ONE   = 32'(1) << GEN_SHIFT;
    localparam logic [31:0] SLOT_MASK = 32'(SLOTS - 1);

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_HANDLE = 2'd1;
    localparam logic [1:0] STAT_NO_SLOT    = 2'd2;
    localparam logic [1:0] STAT_NO_MEM     = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [HANDLE_W-1:0] handle;
        logic [FSLOT_W-1:0]  free_slot;
        logic [HANDLE_W-1:0] parent_handle;
        logic                check_permission;
        logic [HANDLE_W-1:0] current_handle;
        logic                memory_available;
    } item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] result_handle;
        logic [FSLOT_W-1:0]  result_slot;
        logic                io_privileged;
    } result_t;

    typedef struct packed {
        logic                active;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] parent;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } slot_req_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } stack_req_t;

    typedef struct packed {
        logic               clearing;
        logic               busy;
        logic [COUNT_W-1:0] count;
    } ctrl_stat_t;

endpackage

// File: rtl/core/gha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/gha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: clears the tables after reset, then reads, modifies and writes
// back the slot table and the free-slot stack for one action at a time.
// ----------------------------------------------------------------------------
module gha_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  gha_pkg::item_t               in_item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output gha_pkg::result_t             res,
    output gha_pkg::slot_req_t           slot_req,
    input  gha_pkg::entry_t              slot_rdata,
    output gha_pkg::stack_req_t          stack_req,
    input  logic [gha_pkg::SLOT_W-1:0]   stack_rdata,
    output gha_pkg::ctrl_stat_t          stat
);

    gha_pkg::state_t              state_reg, state_next;
    gha_pkg::item_t               item_reg, item_next;
    logic [gha_pkg::SLOT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [gha_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [gha_pkg::SLOT_W-1:0]   sel_reg, sel_next;

    logic [31:0]                  gen_sum;
    logic [31:0]                  gen_val;
    logic [gha_pkg::HANDLE_W-1:0] new_handle;
    logic [gha_pkg::SLOT_W-1:0]   fs_idx;
    logic                         fs_range_bad;
    logic                         perm_bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gha_pkg::S_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= gha_pkg::COUNT_W'(gha_pkg::SLOTS);
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
        end
        item_reg <= item_next;
        sel_reg  <= sel_next;
    end

    // Next generation: step above the slot bits, restart on wrap or overflow.
    always_comb begin
        gen_sum = {1'b0, slot_rdata.handle} + gha_pkg::GEN_ONE;
        gen_val = gen_sum & ~gha_pkg::SLOT_MASK;
        if (gen_val == '0 || gen_val[31]) begin
            gen_val = gha_pkg::GEN_ONE;
        end
        new_handle = gen_val[gha_pkg::HANDLE_W-1:0]
                   | gha_pkg::HANDLE_W'(sel_reg);
    end

    assign fs_idx       = gha_pkg::SLOT_W'(item_reg.free_slot);
    assign fs_range_bad = 32'(item_reg.free_slot) >= 32'(gha_pkg::SLOTS);
    assign perm_bad     = item_reg.check_permission
                       && item_reg.handle != item_reg.current_handle
                       && slot_rdata.parent != item_reg.current_handle;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gha_pkg::S_CLEAR: begin
                if (clr_idx_reg == gha_pkg::SLOT_W'(gha_pkg::SLOTS - 1)) begin
                    state_next = gha_pkg::S_IDLE;
                end
            end
            gha_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = (in_item.action == gha_pkg::ACT_ALLOC)
                               ? gha_pkg::S_POP : gha_pkg::S_EXEC;
                end
            end
            gha_pkg::S_POP: begin
                state_next = gha_pkg::S_EXEC;
            end
            gha_pkg::S_EXEC: begin
                if (res_ready) begin
                    state_next = gha_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        item_next    = item_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;
        sel_next     = sel_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        slot_req     = '0;
        stack_req    = '0;
        unique case (state_reg)
            gha_pkg::S_CLEAR: begin
                // Zero the slot table, load the stack with slot 0 on top.
                slot_req.we     = 1'b1;
                slot_req.waddr  = clr_idx_reg;
                stack_req.we    = 1'b1;
                stack_req.waddr = clr_idx_reg;
                stack_req.wdata = gha_pkg::SLOT_W'(gha_pkg::SLOTS - 1) - clr_idx_reg;
                clr_idx_next    = clr_idx_reg + 1'b1;
            end
            gha_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next       = in_item;
                    stack_req.re    = 1'b1;
                    stack_req.raddr = count_reg[gha_pkg::SLOT_W-1:0] - 1'b1;
                    slot_req.re     = 1'b1;
                    slot_req.raddr  = (in_item.action == gha_pkg::ACT_FREE)
                                    ? gha_pkg::SLOT_W'(in_item.free_slot)
                                    : in_item.handle[gha_pkg::SLOT_W-1:0];
                end
            end
            gha_pkg::S_POP: begin
                sel_next       = stack_rdata;
                slot_req.re    = 1'b1;
                slot_req.raddr = stack_rdata;
            end
            gha_pkg::S_EXEC: begin
                if (res_ready) begin
                    res_valid = 1'b1;
                    unique case (item_reg.action)
                        gha_pkg::ACT_ALLOC: begin
                            if (count_reg == '0) begin
                                res.status = gha_pkg::STAT_NO_SLOT;
                            end else if (!item_reg.memory_available) begin
                                res.status = gha_pkg::STAT_NO_MEM;
                            end else begin
                                slot_req.we           = 1'b1;
                                slot_req.waddr        = sel_reg;
                                slot_req.wdata.active = 1'b1;
                                slot_req.wdata.handle = new_handle;
                                slot_req.wdata.parent = item_reg.parent_handle;
                                count_next            = count_reg - 1'b1;
                                res.status            = gha_pkg::STAT_OK;
                                res.result_handle     = new_handle;
                                res.result_slot       = gha_pkg::FSLOT_W'(sel_reg);
                                res.io_privileged     = (sel_reg == gha_pkg::SLOT_W'(1));
                            end
                        end
                        gha_pkg::ACT_FREE: begin
                            if (fs_range_bad) begin
                                res.status = gha_pkg::STAT_BAD_HANDLE;
                            end else if (!slot_rdata.active) begin
                                res.status      = gha_pkg::STAT_OK;
                                res.result_slot = item_reg.free_slot;
                            end else begin
                                // Keep handle and parent, drop the active bit.
                                slot_req.we           = 1'b1;
                                slot_req.waddr        = fs_idx;
                                slot_req.wdata        = slot_rdata;
                                slot_req.wdata.active = 1'b0;
                                if (count_reg < gha_pkg::COUNT_W'(gha_pkg::SLOTS)) begin
                                    stack_req.we    = 1'b1;
                                    stack_req.waddr = count_reg[gha_pkg::SLOT_W-1:0];
                                    stack_req.wdata = fs_idx;
                                    count_next      = count_reg + 1'b1;
                                end
                                res.status        = gha_pkg::STAT_OK;
                                res.result_handle = slot_rdata.handle;
                                res.result_slot   = item_reg.free_slot;
                            end
                        end
                        gha_pkg::ACT_LOOKUP: begin
                            if (item_reg.handle == '0) begin
                                res.status        = gha_pkg::STAT_OK;
                                res.result_handle = item_reg.current_handle;
                                res.result_slot   = gha_pkg::FSLOT_W'(
                                    item_reg.current_handle[gha_pkg::SLOT_W-1:0]);
                            end else if (!slot_rdata.active
                                         || slot_rdata.handle != item_reg.handle
                                         || perm_bad) begin
                                res.status = gha_pkg::STAT_BAD_HANDLE;
                            end else begin
                                res.status        = gha_pkg::STAT_OK;
                                res.result_handle = item_reg.handle;
                                res.result_slot   = gha_pkg::FSLOT_W'(
                                    item_reg.handle[gha_pkg::SLOT_W-1:0]);
                            end
                        end
                        default: begin
                            res.status = gha_pkg::STAT_BAD_HANDLE;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.clearing = (state_reg == gha_pkg::S_CLEAR);
    assign stat.busy     = (state_reg == gha_pkg::S_POP) || (state_reg == gha_pkg::S_EXEC);
    assign stat.count    = count_reg;

endmodule

// File: rtl/core/generation_handle_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_handle_allocator
// Process slot table handing out generation-tagged handles.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request beat on the s_axis channel: tuser carries the action
//   (allocate, free, look up), tdata the operands. Every request produces
//   exactly one result beat on the m_axis channel with a status code, the
//   new or validated handle, the slot index and the I/O privilege flag.
// Sequence:
//   A free or lookup request goes from its accept to the S_EXEC state, where
//   its result is loaded into the output register; an allocate request
//   passes through S_POP first: the free-stack top must be read before the
//   slot entry it names can be read. One request is in flight at a time:
//   the block takes no new request until the slot RAM read, modify and
//   write-back of the last one is done and its result is loaded.
// Reset:
//   After aresetn is released the block runs a clearing pass that zeroes
//   the slot table and reloads the free stack (slot 0 on top);
//   s_axis_tready stays low until it completes.
// Stall:
//   A finished result waits in the output register while the next request
//   is taken; the sequencer holds its result only while that one stays unread.
// ----------------------------------------------------------------------------
module generation_handle_allocator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [30:0] handle, [40:31] free_slot, [71:41] parent_handle,
    // [72] check_permission, [103:73] current_handle, [104] memory_available
    input  logic [111:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [32:2] result_handle, [42:33] result_slot, [43] io_privileged
    output logic [47:0]  m_axis_tdata
);

    gha_pkg::item_t                in_item;
    gha_pkg::result_t              res;
    logic                          res_valid;
    logic                          out_free;
    gha_pkg::slot_req_t            slot_req;
    gha_pkg::entry_t               slot_rdata;
    logic [gha_pkg::ENTRY_W-1:0]   slot_rdata_raw;
    gha_pkg::stack_req_t           stack_req;
    logic [gha_pkg::SLOT_W-1:0]    stack_rdata;
    gha_pkg::ctrl_stat_t           stat;

    logic                          m_valid_reg, m_valid_next;
    gha_pkg::result_t              m_data_reg, m_data_next;

    // Unpack the request beat.
    assign in_item.action           = s_axis_tuser;
    assign in_item.handle           = s_axis_tdata[30:0];
    assign in_item.free_slot        = s_axis_tdata[40:31];
    assign in_item.parent_handle    = s_axis_tdata[71:41];
    assign in_item.check_permission = s_axis_tdata[72];
    assign in_item.current_handle   = s_axis_tdata[103:73];
    assign in_item.memory_available = s_axis_tdata[104];

    // Output register is free when empty or draining this cycle.
    assign out_free = !m_valid_reg || m_axis_tready;

    gha_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res_ready   (out_free),
        .res         (res),
        .slot_req    (slot_req),
        .slot_rdata  (slot_rdata),
        .stack_req   (stack_req),
        .stack_rdata (stack_rdata),
        .stat        (stat)
    );

    // Slot table: active bit, handle and parent per slot.
    gha_ram #(
        .WIDTH (gha_pkg::ENTRY_W),
        .DEPTH (gha_pkg::SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_req.we),
        .waddr (slot_req.waddr),
        .wdata (slot_req.wdata),
        .re    (slot_req.re),
        .raddr (slot_req.raddr),
        .rdata (slot_rdata_raw)
    );

    assign slot_rdata = gha_pkg::entry_t'(slot_rdata_raw);

    // Free-slot LIFO, top at count - 1.
    gha_ram #(
        .WIDTH (gha_pkg::SLOT_W),
        .DEPTH (gha_pkg::SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_req.we),
        .waddr (stack_req.waddr),
        .wdata (stack_req.wdata),
        .re    (stack_req.re),
        .raddr (stack_req.raddr),
        .rdata (stack_rdata)
    );

    // Output register: load a new result, drop a taken one, else hold.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_data_reg.io_privileged, m_data_reg.result_slot,
                            m_data_reg.result_handle, m_data_reg.status};

    // A result is only loaded when the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result loaded over a pending beat");

    // No request is taken during the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clearing |-> !s_axis_tready)
        else $error("request accepted while clearing");

    // One request at a time: after an accept the sequencer is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (stat.busy && !s_axis_tready))
        else $error("sequencer not busy after accept");

    // Free count never exceeds the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= gha_pkg::COUNT_W'(gha_pkg::SLOTS))
        else $error("free count out of range");

endmodule

// File: bench/generation_handle_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_handle_allocator_test
// Self-checking bench for the generation-tagged handle allocator.
// ----------------------------------------------------------------------------
// A local copy of the slot table (generations, active bits, parents, free
// stack) predicts every result beat. The stimulus starts with a short
// directed walk through the table's corner cases. Random traffic follows,
// the sender then holds until every outstanding beat has come back, and a
// second round of random traffic ends the run. Both channels idle and
// stall at random. Every result beat is compared with the oldest expected
// beat, typed in or predicted.
// ----------------------------------------------------------------------------
module generation_handle_allocator_test;

    // Code 3 of the action field has no meaning; the block must answer it as
    // a bad request.
    localparam logic [1:0]                   ACT_UNDEFINED = 2'd3;
    localparam logic [gha_pkg::HANDLE_W-1:0] HANDLE_ALL    = '1;
    localparam logic [gha_pkg::FSLOT_W-1:0]  SLOT_ALL      = '1;
    localparam int                           LIVE_TARGET   = 48;
    localparam int                           RANDOM_ITEMS  = 290;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [30:0] handle, [40:31] free_slot, [71:41] parent_handle,
    // [72] check_permission, [103:73] current_handle, [104] memory_available
    logic [111:0] s_axis_tdata  = '0;
    // [1:0] action
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [1:0] status, [32:2] result_handle, [42:33] result_slot, [43] io_privileged
    logic [47:0]  m_axis_tdata;

    generation_handle_allocator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // Bench copy of the slot table. The free stack grows upward: its top
    // entry sits at free_depth - 1.
    logic [gha_pkg::HANDLE_W-1:0] gen_handle_of [gha_pkg::SLOTS];
    logic                         in_use        [gha_pkg::SLOTS];
    logic [gha_pkg::HANDLE_W-1:0] parent_of     [gha_pkg::SLOTS];
    logic [gha_pkg::SLOT_W-1:0]   free_slots    [gha_pkg::SLOTS];
    int                           free_depth;
    int                           live_slots[$];      // slots currently allocated
    gha_pkg::result_t             awaited_results[$]; // predicted beats, oldest first
    int                           mismatch_count = 0;
    bit                           calm = 1'b0;        // set: neither side idles

    typedef struct {
        gha_pkg::item_t   req;
        bit               typed;  // set: want holds the expected beat, typed in
        gha_pkg::result_t want;
    } row_t;

    function automatic gha_pkg::item_t request(logic [1:0] act,
                                               logic [gha_pkg::HANDLE_W-1:0] h,
                                               logic [gha_pkg::FSLOT_W-1:0] fs,
                                               logic [gha_pkg::HANDLE_W-1:0] par,
                                               logic chk,
                                               logic [gha_pkg::HANDLE_W-1:0] cur,
                                               logic mem);
        gha_pkg::item_t it;
        it.action           = act;
        it.handle           = h;
        it.free_slot        = fs;
        it.parent_handle    = par;
        it.check_permission = chk;
        it.current_handle   = cur;
        it.memory_available = mem;
        return it;
    endfunction

    function automatic gha_pkg::result_t answer(logic [1:0] st,
                                                logic [gha_pkg::HANDLE_W-1:0] h,
                                                logic [gha_pkg::FSLOT_W-1:0] s,
                                                logic io);
        gha_pkg::result_t r;
        r.status        = st;
        r.result_handle = h;
        r.result_slot   = s;
        r.io_privileged = io;
        return r;
    endfunction

    // Apply one accepted request to the bench table; return the beat it owes.
    function automatic gha_pkg::result_t apply_action(gha_pkg::item_t it);
        gha_pkg::result_t           r;
        logic [gha_pkg::SLOT_W-1:0] s;
        logic [32:0]                next_gen;
        r = answer(gha_pkg::STAT_OK, '0, '0, 1'b0);
        case (it.action)
            gha_pkg::ACT_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = gha_pkg::STAT_NO_SLOT;
                end else if (!it.memory_available) begin
                    r.status = gha_pkg::STAT_NO_MEM;
                end else begin
                    s = free_slots[free_depth - 1];
                    // Advance the generation; restart it when it wraps to
                    // zero or leaves the 31-bit handle space.
                    next_gen = ({2'b00, gen_handle_of[s]} + 33'(gha_pkg::GEN_ONE))
                               & ~33'(gha_pkg::SLOT_MASK);
                    if (next_gen == '0 || next_gen > 33'(HANDLE_ALL))
                        next_gen = 33'(gha_pkg::GEN_ONE);
                    gen_handle_of[s] = next_gen[gha_pkg::HANDLE_W-1:0]
                                     | gha_pkg::HANDLE_W'(s);
                    parent_of[s]     = it.parent_handle;
                    in_use[s]        = 1'b1;
                    free_depth--;
                    live_slots.push_back(int'(s));
                    r = answer(gha_pkg::STAT_OK, gen_handle_of[s], s,
                               s == gha_pkg::SLOT_W'(1));
                end
            end
            gha_pkg::ACT_FREE: begin
                s = it.free_slot[gha_pkg::SLOT_W-1:0];
                if (!in_use[s]) begin
                    // Releasing a free slot changes nothing.
                    r.result_slot = s;
                end else begin
                    in_use[s] = 1'b0;
                    free_slots[free_depth] = s;
                    free_depth++;
                    for (int i = 0; i < live_slots.size(); i++) begin
                        if (live_slots[i] == int'(s)) begin
                            live_slots.delete(i);
                            break;
                        end
                    end
                    r = answer(gha_pkg::STAT_OK, gen_handle_of[s], s, 1'b0);
                end
            end
            gha_pkg::ACT_LOOKUP: begin
                s = it.handle[gha_pkg::SLOT_W-1:0];
                if (it.handle == '0) begin
                    // Handle zero names the running process; no table check.
                    r = answer(gha_pkg::STAT_OK, it.current_handle,
                               it.current_handle[gha_pkg::SLOT_W-1:0], 1'b0);
                end else if (!in_use[s] || gen_handle_of[s] != it.handle) begin
                    r.status = gha_pkg::STAT_BAD_HANDLE;
                end else if (it.check_permission && it.handle != it.current_handle
                             && parent_of[s] != it.current_handle) begin
                    r.status = gha_pkg::STAT_BAD_HANDLE;
                end else begin
                    r = answer(gha_pkg::STAT_OK, it.handle, s, 1'b0);
                end
            end
            default: r.status = gha_pkg::STAT_BAD_HANDLE;
        endcase
        return r;
    endfunction

    function automatic logic [111:0] pack_request(gha_pkg::item_t it);
        return {7'd0, it.memory_available, it.current_handle, it.check_permission,
                it.parent_handle, it.free_slot, it.handle};
    endfunction

    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [gha_pkg::SLOT_W-1:0] pick_live();
        return gha_pkg::SLOT_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
    endfunction

    // Random request shaped by the table: frees and lookups mostly hit live
    // slots, and permission checks often name the owner or the parent.
    function automatic gha_pkg::item_t random_request();
        gha_pkg::item_t             it;
        int                         pick;
        logic [gha_pkg::SLOT_W-1:0] s;
        it = request(gha_pkg::ACT_LOOKUP, gha_pkg::HANDLE_W'($urandom()),
                     gha_pkg::FSLOT_W'($urandom()), gha_pkg::HANDLE_W'($urandom()),
                     1'($urandom()), gha_pkg::HANDLE_W'($urandom()),
                     $urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (live_slots.size() == 0 && pick < 90)
            pick = 0;
        else if (live_slots.size() > LIVE_TARGET && pick < 35)
            pick = 40;
        if (pick < 35) begin
            it.action = gha_pkg::ACT_ALLOC;
            if (live_slots.size() != 0 && $urandom_range(0, 1) == 1)
                it.parent_handle = gen_handle_of[pick_live()];
        end else if (pick < 60) begin
            it.action = gha_pkg::ACT_FREE;
            if ($urandom_range(0, 4) != 0)
                it.free_slot = pick_live();
        end else if (pick < 90) begin
            s = pick_live();
            it.handle = gen_handle_of[s];
            case ($urandom_range(0, 3))
                0:       it.current_handle = it.handle;
                1:       it.current_handle = parent_of[s];
                default: ;
            endcase
        end else if (pick < 93) begin
            it.handle = '0;
        end else if (pick < 96) begin
            // Stored handle of any slot: stale or released ones must fail.
            it.handle = gen_handle_of[gha_pkg::SLOT_W'($urandom())];
        end else if (pick >= 98) begin
            it.action = ACT_UNDEFINED;
        end
        return it;
    endfunction

    // Hold one request beat on the input channel until it is taken, then
    // record the beat it owes. tvalid stays high on return.
    task automatic send_beat(input gha_pkg::item_t it, input bit typed,
                             input gha_pkg::result_t want);
        int               gap;
        gha_pkg::result_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_request(it);
        s_axis_tuser  <= it.action;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = apply_action(it);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // Result side: check each beat taken, then decide the next ready.
    initial begin : result_sink
        int               stall;
        gha_pkg::result_t got;
        gha_pkg::result_t want;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got = answer(m_axis_tdata[1:0], m_axis_tdata[32:2],
                             m_axis_tdata[42:33], m_axis_tdata[43]);
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat st=%0d h=%h s=%0d io=%0d",
                             $time, got.status, got.result_handle, got.result_slot,
                             got.io_privileged);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got != want) begin
                        $display({"%0t: result mismatch: expected st=%0d h=%h s=%0d io=%0d,",
                                  " got st=%0d h=%h s=%0d io=%0d"},
                                 $time, want.status, want.result_handle,
                                 want.result_slot, want.io_privileged, got.status,
                                 got.result_handle, got.result_slot, got.io_privileged);
                        mismatch_count++;
                    end
                end
            end
            if (stall == 0 && !calm && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            m_axis_tready <= (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    initial begin : stimulus
        row_t rows[$];

        // Bench table after reset: nothing active, slot 0 on top of the stack.
        for (int i = 0; i < gha_pkg::SLOTS; i++) begin
            gen_handle_of[i] = '0;
            in_use[i]        = 1'b0;
            parent_of[i]     = '0;
            free_slots[i]    = gha_pkg::SLOT_W'(gha_pkg::SLOTS - 1 - i);
        end
        free_depth = gha_pkg::SLOTS;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk. Typed rows follow from the reset state alone.
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, '0, '0, '0, 1'b1, HANDLE_ALL, 1'b0),
                         1'b1, answer(gha_pkg::STAT_OK, HANDLE_ALL, SLOT_ALL, 1'b0)});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1000, '0, '0, 1'b0, '0, 1'b1),
                         1'b1, answer(gha_pkg::STAT_BAD_HANDLE, '0, '0, 1'b0)});
        rows.push_back('{request(gha_pkg::ACT_ALLOC, '0, '0, HANDLE_ALL, 1'b0, '0, 1'b0),
                         1'b1, answer(gha_pkg::STAT_NO_MEM, '0, '0, 1'b0)});
        rows.push_back('{request(gha_pkg::ACT_ALLOC, '0, '0, HANDLE_ALL, 1'b0, '0, 1'b1),
                         1'b1, answer(gha_pkg::STAT_OK, 31'h1000, 10'd0, 1'b0)});
        rows.push_back('{request(gha_pkg::ACT_ALLOC, '0, '0, 31'h1000, 1'b0, '0, 1'b1),
                         1'b1, answer(gha_pkg::STAT_OK, 31'h1001, 10'd1, 1'b1)});
        rows.push_back('{request(gha_pkg::ACT_ALLOC, '0, '0, 31'h1001, 1'b0, '0, 1'b1),
                         1'b1, answer(gha_pkg::STAT_OK, 31'h1002, 10'd2, 1'b0)});
        // Permission: child of current, current itself, neither, no check.
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1001, '0, '0, 1'b1, 31'h1000,
                                 1'b0), 1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1001, '0, '0, 1'b1, 31'h1001,
                                 1'b0), 1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1001, '0, '0, 1'b1, 31'h1002,
                                 1'b0), 1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1001, '0, '0, 1'b0, 31'h1002,
                                 1'b0), 1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1002, '0, '0, 1'b1, '0, 1'b0),
                         1'b0, '0});
        // Right slot, wrong generation.
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h4000_1001, '0, '0, 1'b0, '0,
                                 1'b0), 1'b0, '0});
        // Release slot 1 twice; the second release is ignored.
        rows.push_back('{request(gha_pkg::ACT_FREE, '0, 10'd1, '0, 1'b0, '0, 1'b0),
                         1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_FREE, '0, 10'd1, '0, 1'b0, '0, 1'b0),
                         1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1001, '0, '0, 1'b0, '0, 1'b1),
                         1'b0, '0});
        // Slot 1 comes back from the top of the stack with a new generation.
        rows.push_back('{request(gha_pkg::ACT_ALLOC, '0, '0, '0, 1'b0, '0, 1'b1),
                         1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1001, '0, '0, 1'b0, '0, 1'b0),
                         1'b0, '0});
        rows.push_back('{request(ACT_UNDEFINED, HANDLE_ALL, SLOT_ALL, HANDLE_ALL, 1'b1,
                                 HANDLE_ALL, 1'b1), 1'b1,
                         answer(gha_pkg::STAT_BAD_HANDLE, '0, '0, 1'b0)});
        rows.push_back('{request(gha_pkg::ACT_FREE, HANDLE_ALL, SLOT_ALL, '0, 1'b1, '0,
                                 1'b1), 1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, HANDLE_ALL, '0, '0, 1'b1,
                                 HANDLE_ALL, 1'b0), 1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_FREE, '0, 10'd0, '0, 1'b0, '0, 1'b0),
                         1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, 31'h1000, '0, '0, 1'b0, '0, 1'b0),
                         1'b0, '0});
        rows.push_back('{request(gha_pkg::ACT_LOOKUP, '0, '0, HANDLE_ALL, 1'b0, '0, 1'b1),
                         1'b1, answer(gha_pkg::STAT_OK, '0, '0, 1'b0)});
        rows.push_back('{request(gha_pkg::ACT_ALLOC, '0, '0, HANDLE_ALL, 1'b1, HANDLE_ALL,
                                 1'b1), 1'b0, '0});
        foreach (rows[i])
            send_beat(rows[i].req, rows[i].typed, rows[i].want);

        // Random traffic around a small working set; one stretch runs with
        // no idling on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 120 && n < 180);
            send_beat(random_request(), 1'b0, '0);
        end
        calm = 1'b0;

        // Hold the input channel until every outstanding beat has come back.
        s_axis_tvalid <= 1'b0;
        drain_results();

        // More random traffic on a stack whose order is now scrambled.
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_beat(random_request(), 1'b0, '0);

        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard: several times the slowest legal run, clearing pass included.
    initial begin : watchdog
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/gha_ctrl.sv
rtl/core/generation_handle_allocator.sv
bench/generation_handle_allocator_test.sv
